// ----- sv/pfse_pkg.sv -----
// shared types and constants for the polynomial fit squared error block
`default_nettype none

package pfse_pkg;

  // field widths
  localparam int unsigned X_W       = 5;
  localparam int unsigned Y_W       = 5;
  localparam int unsigned COEFF_W   = 24;
  localparam int unsigned TC_W      = 3;
  localparam int unsigned OUT_W     = 48;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 3 * OUT_W;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = COEFF_W;
  localparam int unsigned REG_TERM_COUNT = 0;
  localparam int unsigned REG_COEFF_BASE = 1;

  // default number of cells in the chain
  localparam int unsigned MAX_TERMS_DEF = 7;
  localparam int unsigned TERM_COUNT_RESET = 1;

  // item travelling down the cell chain
  typedef struct packed {
    logic                  valid;
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic                  last;
  } pfse_link_t;

endpackage

`default_nettype wire

// ----- sv/pfse_cell.sv -----
// one polynomial term cell: holds a coefficient, adds its term and steps the power of x
`default_nettype none

module pfse_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW_W  = 26,
  parameter int unsigned ACC_W = 53
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   coeff_we_i,
  input  wire  [pfse_pkg::COEFF_W-1:0]          coeff_data_i,
  input  wire  [pfse_pkg::TC_W-1:0]             term_n_i,
  input  wire  pfse_pkg::pfse_link_t            link_i,
  input  wire  signed [PW_W-1:0]                pw_i,
  input  wire  signed [ACC_W-1:0]               acc_i,
  output pfse_pkg::pfse_link_t                  link_o,
  output logic signed [PW_W-1:0]                pw_o,
  output logic signed [ACC_W-1:0]               acc_o
);
  import pfse_pkg::*;

  localparam int unsigned PROD_W = COEFF_W + PW_W;

  logic signed [COEFF_W-1:0]  coeff_q;
  logic                       valid_q;
  pfse_link_t                 link_q;
  logic signed [PW_W-1:0]     pw_q, pw_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PW_W+X_W-1:0] pw_next;
  logic                       term_used;

  // term k contributes only while k is below the term count
  assign term_used = (TC_W'(INDEX) < term_n_i);

  always_comb begin
    prod    = coeff_q * pw_i;
    pw_next = pw_i * link_i.x;
    pw_d    = pw_next[PW_W-1:0];
    acc_d   = term_used ? (acc_i + ACC_W'(prod)) : acc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (coeff_we_i) begin
        coeff_q <= coeff_data_i;
      end
      valid_q <= link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_i.valid) begin
      link_q <= link_i;
      pw_q   <= pw_d;
      acc_q  <= acc_d;
    end
  end

  always_comb begin
    link_o       = link_q;
    link_o.valid = valid_q;
    pw_o         = pw_q;
    acc_o        = acc_q;
  end

endmodule

`default_nettype wire

// ----- sv/pfse_score.sv -----
// saturation, squared residual and running sum behind the cell chain
`default_nettype none

module pfse_score #(
  parameter int unsigned ACC_W = 53
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  pfse_pkg::pfse_link_t         link_i,
  input  wire  signed [ACC_W-1:0]            acc_i,
  output logic                               busy_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [pfse_pkg::OUT_W-1:0]         pred_o,
  output logic [pfse_pkg::OUT_W-1:0]         err_o,
  output logic [pfse_pkg::OUT_W-1:0]         sum_o,
  output logic                               last_o
);
  import pfse_pkg::*;

  localparam int unsigned EXT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W + 1;
  localparam int unsigned RES_W = OUT_W + 1;
  localparam int unsigned SQ_W  = 2 * MAG_W;

  // stage a: saturated prediction
  logic                       a_valid_q;
  logic signed [OUT_W-1:0]    a_pred_q, a_pred_d;
  logic signed [Y_W-1:0]      a_y_q;
  logic                       a_last_q;
  logic signed [EXT_W-1:0]    acc_ext;
  logic                       acc_fits;

  // stage b: residual magnitude
  logic                       b_valid_q;
  logic [MAG_W-1:0]           b_mag_q;
  logic                       b_big_q, b_big_d;
  logic [OUT_W-1:0]           b_pred_q;
  logic                       b_last_q;
  logic signed [RES_W-1:0]    res;
  logic [RES_W-1:0]           mag;

  // stage c: square, waits here while the output register is full
  logic                       c_valid_q;
  logic [SQ_W-1:0]            c_sq_q;
  logic                       c_big_q;
  logic [OUT_W-1:0]           c_pred_q;
  logic                       c_last_q;
  logic                       c_move;

  // output register and accumulator
  logic                       out_valid_q;
  logic [OUT_W-1:0]           out_pred_q, out_err_q, out_sum_q;
  logic                       out_last_q;
  logic [OUT_W-1:0]           accum_q, accum_d;
  logic [OUT_W-1:0]           err_d, sum_d;
  logic [OUT_W:0]             sum_wide;

  always_comb begin
    acc_ext  = EXT_W'(acc_i);
    acc_fits = (acc_ext[EXT_W-1:OUT_W-1] == '0) || (acc_ext[EXT_W-1:OUT_W-1] == '1);
    if (acc_fits) begin
      a_pred_d = acc_ext[OUT_W-1:0];
    end else if (acc_ext[EXT_W-1]) begin
      a_pred_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      a_pred_d = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_comb begin
    res = $signed({{(RES_W-Y_W-FRAC_W){a_y_q[Y_W-1]}}, a_y_q, {FRAC_W{1'b0}}})
        - $signed({a_pred_q[OUT_W-1], a_pred_q});
    mag     = res[RES_W-1] ? RES_W'(-res) : RES_W'(res);
    b_big_d = |mag[RES_W-1:MAG_W];
  end

  assign c_move = c_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    err_d    = c_big_q ? {OUT_W{1'b1}} : c_sq_q[SQ_W-1:FRAC_W];
    sum_wide = {1'b0, accum_q} + {1'b0, err_d};
    sum_d    = sum_wide[OUT_W] ? {OUT_W{1'b1}} : sum_wide[OUT_W-1:0];
    accum_d  = c_last_q ? '0 : sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      accum_q     <= '0;
    end else begin
      a_valid_q <= link_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q || (c_valid_q && !c_move);
      if (c_move) begin
        out_valid_q <= 1'b1;
        accum_q     <= accum_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_i.valid) begin
      a_pred_q <= a_pred_d;
      a_y_q    <= link_i.y;
      a_last_q <= link_i.last;
    end
    if (a_valid_q) begin
      b_mag_q  <= mag[MAG_W-1:0];
      b_big_q  <= b_big_d;
      b_pred_q <= a_pred_q;
      b_last_q <= a_last_q;
    end
    if (b_valid_q) begin
      c_sq_q   <= b_mag_q * b_mag_q;
      c_big_q  <= b_big_q;
      c_pred_q <= b_pred_q;
      c_last_q <= b_last_q;
    end
    if (c_move) begin
      out_pred_q <= c_pred_q;
      out_err_q  <= err_d;
      out_sum_q  <= sum_d;
      out_last_q <= c_last_q;
    end
  end

  assign busy_o      = a_valid_q || b_valid_q || c_valid_q;
  assign out_valid_o = out_valid_q;
  assign pred_o      = out_pred_q;
  assign err_o       = out_err_q;
  assign sum_o       = out_sum_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ----- sv/polynomial_fit_squared_error.sv -----
// top level of the polynomial fit squared error scorer
//
// scores a polynomial with Q8.16 coefficients against a stream of integer points
// input channel s_axis: tdata carries x and y, tlast marks the last point of a set
// output channel m_axis: tdata carries prediction, squared error and running sum,
//   all Q32.16; tlast repeats the last-point mark of the item
// config channel: cfg_index_i 0 writes the term count, 1 + k writes coefficient k;
//   cfg_ready_o is always high, write only while no item is in flight
// the polynomial is summed along a row of MAX_TERMS cells, one term per cell,
//   each cell passing the running sum and the next power of x to its neighbor
// three more stages saturate, take the residual magnitude and square it, and the
//   output register adds the square to the running sum
// the cell row and the score stages hold one item at a time, so a new item is
//   accepted only once the previous one has left the square stage
// a finished item waits in the output register while the next item runs down
//   the chain; that next item then waits in the square stage until the output
//   register is taken, and no new item is accepted meanwhile
// reset empties the pipeline, clears the running sum and the coefficients, and
//   sets the term count to one
// the running sum clears after the item marked last
`default_nettype none

module polynomial_fit_squared_error #(
  parameter int unsigned MAX_TERMS = pfse_pkg::MAX_TERMS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // config write channel
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [pfse_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [pfse_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input points
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire  [pfse_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // x_point, y_target
  input  wire                                 s_axis_tlast_i,  // last_point
  // results
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  output logic [pfse_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,  // predicted, squared_error,
                                                               // fitness_sum
  output logic                                m_axis_tlast_o   // sum_final
);
  import pfse_pkg::*;

  // power of x entering cell k is x^k with k up to MAX_TERMS-1, |x| up to 16
  localparam int unsigned PW_W  = 4 * (MAX_TERMS - 1) + 2;
  localparam int unsigned ACC_W = COEFF_W + PW_W + $clog2(MAX_TERMS + 1);

  logic [TC_W-1:0]         term_count_q;
  logic [TC_W-1:0]         term_n;
  logic                    chain_busy;
  logic                    score_busy;
  logic                    in_take;

  pfse_link_t              link  [MAX_TERMS+1];
  logic signed [PW_W-1:0]  pw    [MAX_TERMS+1];
  logic signed [ACC_W-1:0] acc   [MAX_TERMS+1];
  logic [MAX_TERMS-1:0]    cell_we;

  logic [OUT_W-1:0]        pred, err, sum;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TC_W'(TERM_COUNT_RESET);
    end else if (cfg_valid_i && (cfg_index_i == CFG_IDX_W'(REG_TERM_COUNT))) begin
      term_count_q <= cfg_data_i[TC_W-1:0];
    end
  end

  // term counts above the number of cells use every cell
  assign term_n = (term_count_q > TC_W'(MAX_TERMS)) ? TC_W'(MAX_TERMS) : term_count_q;

  // one item at a time: accept only when the chain and score stages are empty
  always_comb begin
    chain_busy = 1'b0;
    for (int k = 1; k <= MAX_TERMS; k++) begin
      chain_busy = chain_busy | link[k].valid;
    end
  end

  assign s_axis_tready_o = !(chain_busy || score_busy);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // head of the chain: x^0 = 1 and an empty sum
  always_comb begin
    link[0].valid = in_take;
    link[0].x     = s_axis_tdata_i[X_W-1:0];
    link[0].y     = s_axis_tdata_i[X_W+Y_W-1:X_W];
    link[0].last  = s_axis_tlast_i;
    pw[0]         = PW_W'(1);
    acc[0]        = '0;
  end

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
    assign cell_we[k] = cfg_valid_i && (cfg_index_i == CFG_IDX_W'(REG_COEFF_BASE + k));

    pfse_cell #(
      .INDEX (k),
      .PW_W  (PW_W),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .coeff_we_i   (cell_we[k]),
      .coeff_data_i (cfg_data_i[COEFF_W-1:0]),
      .term_n_i     (term_n),
      .link_i       (link[k]),
      .pw_i         (pw[k]),
      .acc_i        (acc[k]),
      .link_o       (link[k+1]),
      .pw_o         (pw[k+1]),
      .acc_o        (acc[k+1])
    );
  end

  pfse_score #(
    .ACC_W (ACC_W)
  ) u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .link_i      (link[MAX_TERMS]),
    .acc_i       (acc[MAX_TERMS]),
    .busy_o      (score_busy),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .pred_o      (pred),
    .err_o       (err),
    .sum_o       (sum),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {sum, err, pred};

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for the polynomial fit squared error scorer
`timescale 1ns / 100ps

module tb;
  import pfse_pkg::*;

  localparam int PIPE_DEPTH = MAX_TERMS_DEF + 4;
  localparam int RANDOM_PHASES = 37;
  localparam int POINTS_PER_PHASE = 50;
  localparam logic [OUT_W-1:0] FULL_SCALE = {OUT_W{1'b1}};
  localparam logic [OUT_W-1:0] PRED_TOP = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] PRED_BOTTOM = {1'b1, {(OUT_W-1){1'b0}}};
  localparam longint PRED_MAX = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint PRED_MIN = -(longint'(1) << (OUT_W - 1));
  localparam longint unsigned ONE_Q16 = 64'd1 << FRAC_W;

  typedef struct packed {
    logic [OUT_W-1:0] predicted;
    logic [OUT_W-1:0] squared_error;
    logic [OUT_W-1:0] fitness_sum;
    logic             sum_final;
  } score_t;

  typedef struct {
    bit     is_write;
    int     reg_idx;
    int     reg_val;
    int     x;
    int     y;
    bit     last;
    bit     typed;
    score_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;  // x_point, y_target
  logic s_axis_tlast_i = 1'b0;                // last_point
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;      // predicted, squared_error, fitness_sum
  logic m_axis_tlast_o;                       // sum_final

  // mirror of the block's registers and running sum
  logic [TC_W-1:0] terms_cfg;
  logic signed [COEFF_W-1:0] coeff_cfg [MAX_TERMS_DEF];
  logic [OUT_W-1:0] error_sum;

  score_t pending_scores[$];
  stim_row_t directed_rows[$];
  bit steady_flow;
  int score_errors;
  int points_sent, sets_closed, reg_writes;
  int preds_clipped, errors_clipped, sums_pinned;

  polynomial_fit_squared_error dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // saturated polynomial value, clipped residual square and running sum for one point
  function automatic score_t score_point(logic signed [X_W-1:0] x,
                                         logic signed [Y_W-1:0] y, logic last);
    score_t s;
    longint poly, pw, resid;
    longint unsigned mag, sq, total;
    poly = 0;
    pw = 1;
    for (int k = 0; k < MAX_TERMS_DEF && k < int'(terms_cfg); k++) begin
      poly += longint'(coeff_cfg[k]) * pw;
      pw *= longint'(x);
    end
    if (poly > PRED_MAX) poly = PRED_MAX;
    if (poly < PRED_MIN) poly = PRED_MIN;
    if (poly == PRED_MAX || poly == PRED_MIN) preds_clipped++;
    resid = longint'(y) * longint'(ONE_Q16) - poly;
    mag = (resid < 0) ? longint'(-resid) : resid;
    // residual of 2^32 or more squares beyond 48 bits
    if (mag >= (64'd1 << MAG_W)) begin
      sq = FULL_SCALE;
      errors_clipped++;
    end else begin
      sq = (mag * mag) >> FRAC_W;
    end
    total = error_sum + sq;
    if (total > FULL_SCALE) total = FULL_SCALE;
    if (total == FULL_SCALE) sums_pinned++;
    error_sum = last ? '0 : total[OUT_W-1:0];
    s.predicted = poly[OUT_W-1:0];
    s.squared_error = sq[OUT_W-1:0];
    s.fitness_sum = total[OUT_W-1:0];
    s.sum_final = last;
    return s;
  endfunction

  function automatic void add_write(int idx, int val);
    stim_row_t r;
    r = '{default: 0};
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_point(int x, int y, bit last, bit typed = 1'b0,
                                    logic [OUT_W-1:0] pred = '0,
                                    logic [OUT_W-1:0] err = '0,
                                    logic [OUT_W-1:0] sum = '0);
    stim_row_t r;
    r = '{default: 0};
    r.x = x;
    r.y = y;
    r.last = last;
    r.typed = typed;
    r.want = '{predicted: pred, squared_error: err, fitness_sum: sum, sum_final: last};
    directed_rows = {directed_rows, r};
  endfunction

  // coefficient mix: extremes, zero, any value, and values whose range shrinks
  // with k to offset the growth of x^k
  function automatic int pick_coeff(int k);
    int span;
    span = 1 << (20 - 2 * k);
    case ($urandom_range(0, 7))
      0: return int'($urandom_range(0, 24'hFFFFFF));
      1: return 8388607;
      2: return -8388608;
      3: return 0;
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  task automatic write_reg(int idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[CFG_IDX_W-1:0];
    cfg_data_i <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_TERM_COUNT) terms_cfg = val[TC_W-1:0];
    else coeff_cfg[idx - REG_COEFF_BASE] = val[COEFF_W-1:0];
    reg_writes++;
  endtask

  // hold off the points until every result has come back
  task automatic drain_scores();
    s_axis_tvalid_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_point(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic last,
                            bit typed, score_t want);
    int gap;
    score_t calc;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    // config channel goes quiet once points flow again
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{(IN_DATA_W - X_W - Y_W){1'b0}}, y, x};
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    calc = score_point(x, y, last);
    pending_scores = {pending_scores, (typed ? want : calc)};
    points_sent++;
    if (last) sets_closed++;
  endtask

  // result side: random stall before each item, none in steady-flow phases
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    score_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.predicted = m_axis_tdata_o[OUT_W-1:0];
      got.squared_error = m_axis_tdata_o[2*OUT_W-1:OUT_W];
      got.fitness_sum = m_axis_tdata_o[3*OUT_W-1:2*OUT_W];
      got.sum_final = m_axis_tlast_o;
      if (pending_scores.size() == 0) begin
        score_errors++;
        if (score_errors <= 10)
          $display("unexpected item: pred %h err %h sum %h last %b",
                   got.predicted, got.squared_error, got.fitness_sum, got.sum_final);
      end else begin
        want = pending_scores.pop_front();
        if (got !== want) begin
          score_errors++;
          if (score_errors <= 10) begin
            $display("mismatch: expected pred %h err %h sum %h last %b",
                     want.predicted, want.squared_error, want.fitness_sum, want.sum_final);
            $display("          got      pred %h err %h sum %h last %b",
                     got.predicted, got.squared_error, got.fitness_sum, got.sum_final);
          end
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int set_left;
    terms_cfg = TC_W'(TERM_COUNT_RESET);
    foreach (coeff_cfg[k]) coeff_cfg[k] = '0;
    error_sum = '0;
    set_left = 0;

    // reset state: one term, zero coefficients, so prediction is zero
    add_point(-16, -16, 1'b0, 1'b1, '0, 48'd16777216, 48'd16777216);
    add_point(15, 15, 1'b1, 1'b1, '0, 48'd14745600, 48'd31522816);
    add_point(0, 0, 1'b1, 1'b1, '0, '0, '0);
    // zero terms ignores even a full-scale constant
    add_write(REG_TERM_COUNT, 0);
    add_write(REG_COEFF_BASE + 0, 8388607);
    add_point(5, -16, 1'b1, 1'b1, '0, 48'd16777216, 48'd16777216);
    // seven terms, top powers at opposite extremes: prediction clips high,
    // sum sticks at full scale until the set closes
    add_write(REG_TERM_COUNT, 7);
    for (int k = 0; k < 5; k++) add_write(REG_COEFF_BASE + k, 0);
    add_write(REG_COEFF_BASE + 5, -8388608);
    add_write(REG_COEFF_BASE + 6, 8388607);
    add_point(-16, 0, 1'b0, 1'b1, PRED_TOP, FULL_SCALE, FULL_SCALE);
    add_point(15, 15, 1'b0);
    add_point(0, -16, 1'b1, 1'b1, '0, 48'd16777216, FULL_SCALE);
    add_point(0, 0, 1'b1, 1'b1, '0, '0, '0);
    // swapped extremes: prediction clips low
    add_write(REG_COEFF_BASE + 5, 8388607);
    add_write(REG_COEFF_BASE + 6, -8388608);
    add_point(-16, 15, 1'b1, 1'b1, PRED_BOTTOM, FULL_SCALE, FULL_SCALE);
    add_point(-1, -1, 1'b0);
    add_point(1, 1, 1'b1);
    // half as the only term
    add_write(REG_TERM_COUNT, 1);
    add_write(REG_COEFF_BASE + 0, 32768);
    add_point(3, 0, 1'b0, 1'b1, 48'd32768, 48'd16384, 48'd16384);
    add_point(-7, 1, 1'b1, 1'b1, 48'd32768, 48'd16384, 48'd32768);
    // six terms leave the top coefficient out
    add_write(REG_TERM_COUNT, 6);
    add_write(REG_COEFF_BASE + 0, -8388608);
    add_write(REG_COEFF_BASE + 5, 1);
    add_point(-16, -16, 1'b0);
    add_point(15, 15, 1'b0);
    add_point(-1, 7, 1'b0);
    add_point(2, -3, 1'b1);
    // residual right at and just under 2^32
    add_write(REG_TERM_COUNT, 5);
    add_write(REG_COEFF_BASE + 0, 0);
    add_write(REG_COEFF_BASE + 4, 65536);
    add_point(-16, 0, 1'b0, 1'b1, 48'd4294967296, FULL_SCALE, FULL_SCALE);
    add_point(-16, 1, 1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        drain_scores();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_point(X_W'(directed_rows[i].x), Y_W'(directed_rows[i].y),
                   directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_scores();
      steady_flow = (phase % 4 == 3);
      write_reg(REG_TERM_COUNT, $urandom_range(0, 7));
      for (int k = 0; k < MAX_TERMS_DEF; k++)
        if ($urandom_range(0, 2) != 0) write_reg(REG_COEFF_BASE + k, pick_coeff(k));
      for (int n = 0; n < POINTS_PER_PHASE; n++) begin
        if (set_left == 0) set_left = $urandom_range(1, 8);
        set_left--;
        send_point(X_W'($urandom_range(0, 31)), Y_W'($urandom_range(0, 31)),
                   set_left == 0, 1'b0, '0);
      end
    end

    drain_scores();
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);

    $display("covered %0d points in %0d closed sets, %0d register writes",
             points_sent, sets_closed, reg_writes);
    $display("%0d predictions clipped, %0d squares clipped, %0d sums at full scale",
             preds_clipped, errors_clipped, sums_pinned);
    if (score_errors == 0 && pending_scores.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pfse_pkg.sv
sv/pfse_cell.sv
sv/pfse_score.sv
sv/polynomial_fit_squared_error.sv
sim/tb.sv
